// File: hdl/rsdd_pkg.sv
// Shared types and constants of the record stream demultiplexer.
`timescale 1ns / 1ps
`default_nettype none
package rsdd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 9;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [COUNT_W-1:0] chan_count_t;

	// Parser phase: which kind of byte the stream carries next.
	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_ID    = 2'd1,
		PH_LEN   = 2'd2,
		PH_DATA  = 2'd3
	} phase_t;

	// One result word as it travels through the queue.
	typedef struct packed {
		byte_t channel;
		byte_t data_byte;
		logic  end_of_record;
		logic  end_of_packet;
		logic  unknown_channel;
	} result_t;

	// Write side of the queue, driven by the front end.
	typedef struct packed {
		logic    valid;
		result_t word;
	} push_t;

endpackage
`default_nettype wire

// File: hdl/rsdd_if.sv
// Channel interfaces: byte input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface rsdd_stream_if;
	logic                 valid;
	logic                 ready;
	logic [7:0]           stream_byte;
	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rsdd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] channel;
	logic [7:0] data_byte;
	logic       end_of_record;
	logic       end_of_packet;
	logic       unknown_channel;
	modport source (output valid, output channel, output data_byte, output end_of_record,
		output end_of_packet, output unknown_channel, input ready);
	modport sink   (input valid, input channel, input data_byte, input end_of_record,
		input end_of_packet, input unknown_channel, output ready);
endinterface

interface rsdd_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] channel_count;
	modport source (output valid, output channel_count, input ready);
	modport sink   (input valid, input channel_count, output ready);
endinterface
`default_nettype wire

// File: hdl/rsdd_front.sv
// Front end: parses the framed byte stream and pushes result words.
`timescale 1ns / 1ps
`default_nettype none
module rsdd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	rsdd_stream_if.sink          stream,
	rsdd_cfg_if.sink             cfg,
	input  wire logic            queue_full,
	output rsdd_pkg::push_t      push
);
	import rsdd_pkg::*;

	phase_t      phase_q, phase_nxt;
	byte_t       records_left_q;
	byte_t       current_channel_q;
	byte_t       bytes_left_q;
	logic        dropping_q;
	chan_count_t channel_count_q;

	logic  accept;
	byte_t b;
	byte_t rl_dec;
	byte_t bl_dec;
	logic  unknown;

	assign stream.ready = !queue_full;
	assign cfg.ready    = 1'b1;
	assign accept       = stream.valid && !queue_full;
	assign b            = stream.stream_byte;
	assign rl_dec       = records_left_q - 8'd1;
	assign bl_dec       = bytes_left_q - 8'd1;
	assign unknown      = {1'b0, current_channel_q} >= channel_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= '0;
		end else if (cfg.valid) begin
			channel_count_q <= cfg.channel_count;
		end
	end

	// Next phase.
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_COUNT: phase_nxt = (b == 8'd0) ? PH_COUNT : PH_ID;
			PH_ID:    phase_nxt = PH_LEN;
			PH_LEN: begin
				if (b != 8'd0) begin
					phase_nxt = PH_DATA;
				end else begin
					phase_nxt = (rl_dec == 8'd0) ? PH_COUNT : PH_ID;
				end
			end
			PH_DATA: begin
				if (bl_dec == 8'd0) begin
					phase_nxt = (records_left_q == 8'd0) ? PH_COUNT : PH_ID;
				end
			end
			default: phase_nxt = PH_COUNT;
		endcase
	end

	// Result word for the byte on offer.
	always_comb begin
		push.valid                = 1'b0;
		push.word.channel         = current_channel_q;
		push.word.data_byte       = 8'd0;
		push.word.end_of_record   = 1'b0;
		push.word.end_of_packet   = 1'b0;
		push.word.unknown_channel = 1'b0;
		case (phase_q)
			PH_LEN: begin
				push.valid                = accept && unknown;
				push.word.end_of_record   = 1'b1;
				push.word.end_of_packet   = (rl_dec == 8'd0);
				push.word.unknown_channel = 1'b1;
			end
			PH_DATA: begin
				push.valid              = accept && !dropping_q;
				push.word.data_byte     = b;
				push.word.end_of_record = (bl_dec == 8'd0);
				push.word.end_of_packet = (bl_dec == 8'd0) && (records_left_q == 8'd0);
			end
			default: push.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_COUNT;
			records_left_q    <= '0;
			current_channel_q <= '0;
			bytes_left_q      <= '0;
			dropping_q        <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			case (phase_q)
				PH_COUNT: records_left_q <= b;
				PH_ID:    current_channel_q <= b;
				PH_LEN: begin
					records_left_q <= rl_dec;
					bytes_left_q   <= b;
					dropping_q     <= unknown;
				end
				PH_DATA:  bytes_left_q <= bl_dec;
				default:  bytes_left_q <= bytes_left_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (stream.valid && stream.ready))
		else $error("result pushed without an accepted byte");
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (bytes_left_q != 8'd0))
		else $error("data phase with no bytes left");
	a_id_records: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ID) |-> (records_left_q != 8'd0))
		else $error("id phase with no records left");
`endif
endmodule
`default_nettype wire

// File: hdl/rsdd_queue.sv
// Short queue of result words between front end and output stage.
`timescale 1ns / 1ps
`default_nettype none
module rsdd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rsdd_pkg::push_t   push,
	output logic                   full,
	output logic                   empty,
	output rsdd_pkg::result_t      head,
	input  wire logic              pop
);
	import rsdd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t         entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full))
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count out of range");
`endif
endmodule
`default_nettype wire

// File: hdl/rsdd_back.sv
// Output stage: registers the queue head onto the result channel.
`timescale 1ns / 1ps
`default_nettype none
module rsdd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire rsdd_pkg::result_t head,
	output logic                   pop,
	rsdd_result_if.source          result
);
	import rsdd_pkg::*;

	logic    valid_q;
	result_t word_q;

	assign pop = !empty && (!valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= head;
		end
	end

	assign result.valid           = valid_q;
	assign result.channel         = word_q.channel;
	assign result.data_byte       = word_q.data_byte;
	assign result.end_of_record   = word_q.end_of_record;
	assign result.end_of_packet   = word_q.end_of_packet;
	assign result.unknown_channel = word_q.unknown_channel;
endmodule
`default_nettype wire

// File: hdl/record_stream_demux_deframer_top.sv
// Top level of the record stream demultiplexer and deframer.
// Throughput: one stream word per cycle while the result queue is not full, parsed in the front end.
// A result word passes through the queue and then the output register before it reaches the output.
// The queue of QUEUE_DEPTH words lets the input keep flowing while the output is stalled.
// Reset (arst_n, asynchronous, active low) returns the parser to awaiting a count byte.
`timescale 1ns / 1ps
`default_nettype none
module record_stream_demux_deframer_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	rsdd_stream_if.sink     stream,
	rsdd_cfg_if.sink        cfg,
	rsdd_result_if.source   result
);
	import rsdd_pkg::*;

	// The front end parses each stream word as it arrives and decides, in the
	// same cycle, whether it yields a result word. Result words go into a short
	// queue; the front end stalls the stream only when that queue is full.
	push_t   push;
	logic    queue_full;
	logic    queue_empty;
	result_t queue_head;
	logic    queue_pop;

	rsdd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push)
	);

	// The queue decouples the parser from the consumer of results.
	rsdd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.empty  (queue_empty),
		.head   (queue_head),
		.pop    (queue_pop)
	);

	// The back end holds one word in an output register and refills it from
	// the queue whenever that register is empty or its word is being taken.
	rsdd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (queue_empty),
		.head   (queue_head),
		.pop    (queue_pop),
		.result (result)
	);
endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for the record stream demultiplexer and deframer, self-checking.
`timescale 1ns / 1ps
module tb;
	import rsdd_pkg::*;

	// Generous bound on the run, so that a hang ends the simulation with an error.
	localparam int unsigned CYCLE_LIMIT = 300000;
	// Cycles to let pass once nothing is outstanding, for bytes still in the pipeline.
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned WORDS_PER_SETTING = 220;

	logic clk = 1'b0;
	logic arst_n;

	rsdd_stream_if stream_ch();
	rsdd_cfg_if    cfg_ch();
	rsdd_result_if result_ch();

	record_stream_demux_deframer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	always #2 clk = ~clk;

	// Our own copy of the parser state, advanced once per accepted stream word.
	phase_t      parse_phase  = PH_COUNT;
	byte_t       recs_left    = '0;
	byte_t       rec_channel  = '0;
	byte_t       bytes_left   = '0;
	logic        rec_dropping = 1'b0;
	chan_count_t chan_count   = '0;

	// Result words the block owes us, oldest first.
	result_t expected_words[$];

	// When set, neither side inserts gaps, so back-to-back traffic is exercised too.
	bit steady = 1'b0;

	int unsigned cycle_count   = 0;
	int unsigned failures      = 0;
	int unsigned words_sent    = 0;
	int unsigned words_checked = 0;
	int unsigned unknown_seen  = 0;
	int unsigned packet_ends   = 0;
	int unsigned cfg_writes    = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Works out what one stream word does to the parser and whether it yields a result.
	// The known/unknown decision is taken at the length word, with the register value then.
	function automatic bit predict_byte(input byte_t b, output result_t word);
		word = '0;
		case (parse_phase)
			PH_COUNT: begin
				recs_left   = b;
				parse_phase = (b == 8'd0) ? PH_COUNT : PH_ID;
				return 1'b0;
			end
			PH_ID: begin
				rec_channel = b;
				parse_phase = PH_LEN;
				return 1'b0;
			end
			PH_LEN: begin
				recs_left    = recs_left - 8'd1;
				bytes_left   = b;
				rec_dropping = ({1'b0, rec_channel} >= chan_count);
				if (b == 8'd0)
					parse_phase = (recs_left == 8'd0) ? PH_COUNT : PH_ID;
				else
					parse_phase = PH_DATA;
				if (!rec_dropping)
					return 1'b0;
				// An unknown record reports itself once, here, whatever its length.
				word.channel         = rec_channel;
				word.end_of_record   = 1'b1;
				word.end_of_packet   = (recs_left == 8'd0);
				word.unknown_channel = 1'b1;
				return 1'b1;
			end
			default: begin
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0)
					parse_phase = (recs_left == 8'd0) ? PH_COUNT : PH_ID;
				if (rec_dropping)
					return 1'b0;
				word.channel       = rec_channel;
				word.data_byte     = b;
				word.end_of_record = (bytes_left == 8'd0);
				word.end_of_packet = (bytes_left == 8'd0) && (recs_left == 8'd0);
				return 1'b1;
			end
		endcase
	endfunction

	// Chooses the next stream word from where the parser stands, so that most traffic
	// forms proper packets with random content, with a little noise that breaks framing.
	function automatic byte_t next_stream_byte();
		int unsigned roll;
		int unsigned known_limit;
		roll        = $urandom_range(0, 99);
		known_limit = (chan_count > 9'd256) ? 256 : chan_count;
		if (roll < 5 && parse_phase != PH_COUNT)
			return byte_t'($urandom_range(0, 255));
		case (parse_phase)
			PH_COUNT: begin
				if (roll < 10)
					return 8'd0;
				if (roll < 11)
					return byte_t'($urandom_range(0, 255));
				return byte_t'($urandom_range(1, 4));
			end
			PH_ID: begin
				if (roll < 55 && known_limit > 0)
					return byte_t'($urandom_range(0, known_limit - 1));
				if (roll < 92 && chan_count < 9'd256)
					return byte_t'($urandom_range(chan_count, 255));
				return byte_t'($urandom_range(0, 255));
			end
			PH_LEN: begin
				if (roll < 18)
					return 8'd0;
				if (roll < 19)
					return byte_t'($urandom_range(0, 255));
				return byte_t'($urandom_range(1, 6));
			end
			default:
				return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Offers one stream word after a random gap and waits for the block to take it.
	// With no gap, valid simply stays high from the previous word.
	task automatic send_byte(input byte_t b);
		int unsigned gap;
		result_t     word;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			stream_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_ch.valid       <= 1'b1;
		stream_ch.stream_byte <= b;
		@(posedge clk);
		while (!stream_ch.ready) @(posedge clk);
		words_sent++;
		if (predict_byte(b, word))
			expected_words.push_back(word);
	endtask

	task automatic send_bytes(input byte_t words[]);
		foreach (words[i]) send_byte(words[i]);
	endtask

	// Stops the stream, waits until every owed result has come out and then lets the
	// pipeline run dry, since the last words may have caused no result at all.
	task automatic settle_block();
		stream_ch.valid <= 1'b0;
		wait (expected_words.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_channel_count(input chan_count_t value);
		settle_block();
		cfg_ch.valid         <= 1'b1;
		cfg_ch.channel_count <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		chan_count = value;
		cfg_writes++;
	endtask

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	// Result side: draws a stall before each word, then compares the word it takes
	// against the oldest expectation.
	initial begin
		int unsigned stall;
		result_t     want;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			if (expected_words.size() == 0) begin
				$error("result word for channel 0x%0h arrived with nothing expected",
					result_ch.channel);
				failures++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (want.unknown_channel)
					unknown_seen++;
				if (want.end_of_packet)
					packet_ends++;
				check_field("channel", want.channel, result_ch.channel);
				check_field("data_byte", want.data_byte, result_ch.data_byte);
				check_field("end_of_record", want.end_of_record, result_ch.end_of_record);
				check_field("end_of_packet", want.end_of_packet, result_ch.end_of_packet);
				check_field("unknown_channel", want.unknown_channel,
					result_ch.unknown_channel);
			end
		end
	end

	// Out of reset the channel count is zero, so every id is unknown: the record
	// gives its error word at the length byte and its data is swallowed.
	task automatic test_reset_default();
		send_bytes('{8'd1, 8'd0, 8'd1, 8'hAA});
	endtask

	// With all ids known: the extreme id values, a silent zero-length record, a
	// packet end on the last data byte and an empty packet.
	task automatic test_known_records();
		write_channel_count(9'd256);
		send_bytes('{8'd3, 8'hFF, 8'd2, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80, 8'd1, 8'h5A});
		send_byte(8'd0);
	endtask

	// Ids at the boundary and above: an unknown record with data gives no end
	// marker on its data, and a zero-length unknown record still reports itself.
	task automatic test_unknown_records();
		write_channel_count(9'd3);
		send_bytes('{8'd2, 8'd3, 8'd2, 8'h12, 8'h34, 8'd200, 8'd0});
	endtask

	// The register changes between the id byte and the length byte; the decision
	// must follow the value in force when the length byte arrives.
	task automatic test_config_mid_record();
		write_channel_count(9'd4);
		send_bytes('{8'd2, 8'd5});
		write_channel_count(9'd6);
		send_bytes('{8'd1, 8'h7E, 8'd5});
		write_channel_count(9'd5);
		send_byte(8'd0);
	endtask

	// Random packets under a spread of channel counts, the extremes among them.
	// Every so often both sides stop idling for a stretch.
	task automatic test_random_traffic();
		chan_count_t settings[8];
		settings = '{9'd0, 9'd1, 9'd2, 9'd255, 9'd256, 9'd511, 9'd128, 9'd0};
		settings[7] = chan_count_t'($urandom_range(0, 511));
		foreach (settings[s]) begin
			write_channel_count(settings[s]);
			for (int i = 0; i < WORDS_PER_SETTING; i++) begin
				if (i % 50 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send_byte(next_stream_byte());
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n               <= 1'b0;
		stream_ch.valid      <= 1'b0;
		stream_ch.stream_byte <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.channel_count <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_default();
		test_known_records();
		test_unknown_records();
		test_config_mid_record();
		test_random_traffic();
		settle_block();

		$display("Sent %0d stream words over %0d channel count settings.",
			words_sent, cfg_writes);
		$display("Checked %0d result words: %0d unknown-channel errors, %0d packet ends.",
			words_checked, unknown_seen, packet_ends);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
